### design/spo2_ror_pkg.sv
package spo2_ror_pkg;

   localparam int MAX_SAMPLES_DEF = 512;
   localparam int SAMPLE_BITS_DEF = 18;

   localparam int CFG_BITS = 10;
   localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET = 10'd500;
   localparam logic [CFG_BITS-1:0] IGNORE_COUNT_RESET = 10'd100;

   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_IGNORE_COUNT = 1'b1;

   localparam logic OPC_SAMPLE = 1'b0;
   localparam logic OPC_START = 1'b1;

   localparam int DIV_BITS = 80;
   localparam int ROOT_STEPS = 32;
   localparam int SQ_BITS = 64;
   localparam int RATIO_BITS = 24;
   localparam int PROD_BITS = 43;
   localparam int PCT_BITS = 7;

   localparam logic [22:0] CONST_OFFSET_Q16 = 23'd6666322;
   localparam logic [18:0] CONST_SLOPE_Q16 = 19'd423487;
   localparam logic [RATIO_BITS-1:0] R_MAX_Q16 = 24'hFFFFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OPEN,
      ST_SUM,
      ST_MEAN_R,
      ST_MEAN_I,
      ST_DEV,
      ST_ROOT_R,
      ST_ROOT_I,
      ST_CHECK,
      ST_RATIO,
      ST_SCALE,
      ST_FINAL,
      ST_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      DIV_NONE,
      DIV_RMEAN,
      DIV_IMEAN,
      DIV_RATIO
   } div_sel_type;

   typedef enum logic [1:0] {
      ROOT_NONE,
      ROOT_RED,
      ROOT_IR
   } root_sel_type;

   typedef struct packed {
      logic store;
      logic clear;
      logic rd_en;
      logic acc_sum;
      logic sq_en;
      logic acc_sq;
      div_sel_type div_load;
      logic div_step;
      div_sel_type div_save;
      root_sel_type root_load;
      logic root_step;
      root_sel_type root_save;
      logic mul_ratio;
      logic scale;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_err;
   } dp_status_type;

endpackage

### design/spo2_ratio_of_ratios_top.sv
// SpO2 estimator by the ratio of ratios. A start item (opcode 1) opens a measurement; sample
// items (opcode 0) are then taken one per cycle, the first ignore_count are dropped and the
// next window_length pairs (at least 1, at most MAX_SAMPLES) are stored. Starts while open and
// samples while idle are dropped. The item that fills the window triggers the evaluation,
// during which req_ready is low: one pass over the store for the sums, two 80-step restoring
// divisions for the means, a second pass for the squared deviations, two 32-step integer
// roots, a multiply and an 80-step division for R, then scaling. One result then appears and
// is held until taken; a zero mean or a flat IR window skips the multiply, the division for R
// and the scaling.
module spo2_ratio_of_ratios_top
   import spo2_ror_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_opcode,
   input  logic [SAMPLE_BITS-1:0] req_red_sample,
   input  logic [SAMPLE_BITS-1:0] req_ir_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [PCT_BITS-1:0] rsp_spo2_percent,
   output logic rsp_status,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int FW = $clog2(MAX_SAMPLES + 1);

   dp_cmd_type cmd;
   dp_status_type status;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [FW-1:0] n_win;

   spo2_ror_ctrl #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .AW(AW),
      .FW(FW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .status(status),
      .cmd(cmd),
      .wr_addr(wr_addr),
      .rd_addr(rd_addr),
      .n_out(n_win)
   );

   spo2_ror_dp #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS),
      .AW(AW),
      .FW(FW)
   ) u_dp (
      .clock(clock),
      .cmd(cmd),
      .wr_addr(wr_addr),
      .rd_addr(rd_addr),
      .n_in(n_win),
      .red_sample(req_red_sample),
      .ir_sample(req_ir_sample),
      .status(status),
      .spo2_percent(rsp_spo2_percent),
      .status_bit(rsp_status)
   );

endmodule

### design/spo2_ror_ctrl.sv
module spo2_ror_ctrl
   import spo2_ror_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int AW = $clog2(MAX_SAMPLES),
   parameter int FW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_opcode,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata,
   input  dp_status_type status,
   output dp_cmd_type cmd,
   output logic [AW-1:0] wr_addr,
   output logic [AW-1:0] rd_addr,
   output logic [FW-1:0] n_out
);

   localparam int CW = ($clog2(MAX_SAMPLES + 3) > 7) ? $clog2(MAX_SAMPLES + 3) : 7;

   ctl_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CFG_BITS-1:0] skip_ff, skip_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] n_ff, n_in;
   logic [CFG_BITS-1:0] wl_ff, ic_ff;
   logic req_acc;
   logic [FW-1:0] fill_next;
   logic [FW-1:0] n_eff;
   logic do_sample;
   logic closing;
   logic [CW-1:0] n_ext;

   assign req_acc = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign wr_addr = fill_ff[AW-1:0];
   assign rd_addr = cnt_ff[AW-1:0];
   assign n_out = n_ff;
   assign n_ext = CW'(n_ff);

   always_comb begin
      if (wl_ff == '0) begin
         n_eff = FW'(1);
      end else if (32'(wl_ff) > 32'(MAX_SAMPLES)) begin
         n_eff = FW'(MAX_SAMPLES);
      end else begin
         n_eff = FW'(wl_ff);
      end
   end

   assign fill_next = (32'(fill_ff) < 32'(MAX_SAMPLES)) ? fill_ff + FW'(1) : fill_ff;
   assign do_sample = req_acc && (req_opcode == OPC_SAMPLE) && (state_ff == ST_OPEN)
                      && !(skip_ff < ic_ff);
   assign closing = do_sample && (fill_next >= n_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         skip_ff <= '0;
         fill_ff <= '0;
         n_ff <= '0;
         wl_ff <= WINDOW_LENGTH_RESET;
         ic_ff <= IGNORE_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         skip_ff <= skip_in;
         fill_ff <= fill_in;
         n_ff <= n_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: wl_ff <= csr_wdata;
               CSR_IGNORE_COUNT: ic_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + CW'(1);
      skip_in = skip_ff;
      fill_in = fill_ff;
      n_in = n_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_opcode == OPC_START) begin
               skip_in = '0;
               fill_in = '0;
               state_in = ST_OPEN;
            end
         end
         ST_OPEN: begin
            if (req_acc && req_opcode == OPC_SAMPLE) begin
               if (skip_ff < ic_ff) begin
                  skip_in = skip_ff + CFG_BITS'(1);
               end else begin
                  fill_in = fill_next;
               end
            end
            if (closing) begin
               state_in = ST_SUM;
               cnt_in = '0;
               n_in = n_eff;
            end
         end
         ST_SUM: begin
            if (cnt_ff == n_ext) begin
               state_in = ST_MEAN_R;
               cnt_in = '0;
            end
         end
         ST_MEAN_R: begin
            if (cnt_ff == CW'(DIV_BITS + 1)) begin
               state_in = ST_MEAN_I;
               cnt_in = '0;
            end
         end
         ST_MEAN_I: begin
            if (cnt_ff == CW'(DIV_BITS + 1)) begin
               state_in = ST_DEV;
               cnt_in = '0;
            end
         end
         ST_DEV: begin
            if (cnt_ff == n_ext + CW'(1)) begin
               state_in = ST_ROOT_R;
               cnt_in = '0;
            end
         end
         ST_ROOT_R: begin
            if (cnt_ff == CW'(ROOT_STEPS + 1)) begin
               state_in = ST_ROOT_I;
               cnt_in = '0;
            end
         end
         ST_ROOT_I: begin
            if (cnt_ff == CW'(ROOT_STEPS + 1)) begin
               state_in = ST_CHECK;
               cnt_in = '0;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            state_in = status.zero_err ? ST_OUT : ST_RATIO;
         end
         ST_RATIO: begin
            if (cnt_ff == CW'(DIV_BITS + 1)) begin
               state_in = ST_SCALE;
               cnt_in = '0;
            end
         end
         ST_SCALE: state_in = ST_FINAL;
         ST_FINAL: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_OPEN: begin
            req_ready = 1'b1;
            cmd.store = do_sample && (32'(fill_ff) < 32'(MAX_SAMPLES));
            cmd.clear = closing;
         end
         ST_SUM: begin
            cmd.rd_en = cnt_ff < n_ext;
            cmd.acc_sum = cnt_ff != '0;
         end
         ST_MEAN_R, ST_MEAN_I, ST_RATIO: begin
            if (cnt_ff == '0) begin
               cmd.div_load = (state_ff == ST_MEAN_R) ? DIV_RMEAN :
                              (state_ff == ST_MEAN_I) ? DIV_IMEAN : DIV_RATIO;
            end else if (cnt_ff == CW'(DIV_BITS + 1)) begin
               cmd.div_save = (state_ff == ST_MEAN_R) ? DIV_RMEAN :
                              (state_ff == ST_MEAN_I) ? DIV_IMEAN : DIV_RATIO;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DEV: begin
            cmd.rd_en = cnt_ff < n_ext;
            cmd.sq_en = (cnt_ff != '0) && (cnt_ff <= n_ext);
            cmd.acc_sq = cnt_ff >= CW'(2);
         end
         ST_ROOT_R, ST_ROOT_I: begin
            if (cnt_ff == '0) begin
               cmd.root_load = (state_ff == ST_ROOT_R) ? ROOT_RED : ROOT_IR;
            end else if (cnt_ff == CW'(ROOT_STEPS + 1)) begin
               cmd.root_save = (state_ff == ST_ROOT_R) ? ROOT_RED : ROOT_IR;
            end else begin
               cmd.root_step = 1'b1;
            end
         end
         ST_CHECK: begin
            cmd.finish = status.zero_err;
            cmd.mul_ratio = !status.zero_err;
         end
         ST_SCALE: cmd.scale = 1'b1;
         ST_FINAL: cmd.finish = 1'b1;
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

### design/spo2_ror_dp.sv
module spo2_ror_dp
   import spo2_ror_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int AW = $clog2(MAX_SAMPLES),
   parameter int FW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic clock,
   input  dp_cmd_type cmd,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] rd_addr,
   input  logic [FW-1:0] n_in,
   input  logic [SAMPLE_BITS-1:0] red_sample,
   input  logic [SAMPLE_BITS-1:0] ir_sample,
   output dp_status_type status,
   output logic [PCT_BITS-1:0] spo2_percent,
   output logic status_bit
);

   localparam int SUMW = SAMPLE_BITS + AW;
   localparam int NUMW = ROOT_STEPS + SAMPLE_BITS;

   logic [2*SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
   logic [2*SAMPLE_BITS-1:0] rd_ff;
   logic [SUMW-1:0] rsum_ff, isum_ff;
   logic [2*SAMPLE_BITS-1:0] rsq_ff, isq_ff;
   logic [SQ_BITS-1:0] rsqsum_ff, isqsum_ff;
   logic [SAMPLE_BITS-1:0] rmean_ff, imean_ff;
   logic [DIV_BITS-1:0] dq_ff, dr_ff, dv_ff;
   logic [SQ_BITS-1:0] rv_ff, rr_ff, rb_ff;
   logic [ROOT_STEPS-1:0] root_r_ff, root_i_ff;
   logic [NUMW-1:0] num_ff, den_ff;
   logic [RATIO_BITS-1:0] ratio_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic [PCT_BITS-1:0] pct_ff;
   logic err_ff;

   logic [SAMPLE_BITS-1:0] rd_red, rd_ir, dred, dir;
   logic [DIV_BITS:0] dsh, dsub;
   logic [SQ_BITS-1:0] rtry;
   logic sat;
   logic [PROD_BITS-1:0] off, diff;

   assign rd_red = rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign rd_ir = rd_ff[SAMPLE_BITS-1:0];
   assign dred = (rd_red >= rmean_ff) ? rd_red - rmean_ff : rmean_ff - rd_red;
   assign dir = (rd_ir >= imean_ff) ? rd_ir - imean_ff : imean_ff - rd_ir;
   assign dsh = {dr_ff, dq_ff[DIV_BITS-1]};
   assign dsub = dsh - {1'b0, dv_ff};
   assign rtry = rr_ff + rb_ff;
   assign sat = {8'b0, num_ff} >= {den_ff, 8'b0};
   assign off = PROD_BITS'({CONST_OFFSET_Q16, 16'b0});
   assign diff = off - prod_ff;
   assign status.zero_err = (rmean_ff == '0) || (imean_ff == '0) || (isqsum_ff == '0);
   assign spo2_percent = pct_ff;
   assign status_bit = err_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[wr_addr] <= {red_sample, ir_sample};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         rsum_ff <= '0;
         isum_ff <= '0;
         rsqsum_ff <= '0;
         isqsum_ff <= '0;
      end else begin
         if (cmd.acc_sum) begin
            rsum_ff <= rsum_ff + SUMW'(rd_red);
            isum_ff <= isum_ff + SUMW'(rd_ir);
         end
         if (cmd.acc_sq) begin
            rsqsum_ff <= rsqsum_ff + SQ_BITS'(rsq_ff);
            isqsum_ff <= isqsum_ff + SQ_BITS'(isq_ff);
         end
      end
      if (cmd.sq_en) begin
         rsq_ff <= (2*SAMPLE_BITS)'(dred) * (2*SAMPLE_BITS)'(dred);
         isq_ff <= (2*SAMPLE_BITS)'(dir) * (2*SAMPLE_BITS)'(dir);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.div_load)
         DIV_RMEAN: begin
            dq_ff <= DIV_BITS'(rsum_ff);
            dv_ff <= DIV_BITS'(n_in);
            dr_ff <= '0;
         end
         DIV_IMEAN: begin
            dq_ff <= DIV_BITS'(isum_ff);
            dv_ff <= DIV_BITS'(n_in);
            dr_ff <= '0;
         end
         DIV_RATIO: begin
            dq_ff <= DIV_BITS'({num_ff, 16'b0});
            dv_ff <= DIV_BITS'(den_ff);
            dr_ff <= '0;
         end
         default: begin
            if (cmd.div_step) begin
               if (!dsub[DIV_BITS]) begin
                  dr_ff <= dsub[DIV_BITS-1:0];
                  dq_ff <= {dq_ff[DIV_BITS-2:0], 1'b1};
               end else begin
                  dr_ff <= dsh[DIV_BITS-1:0];
                  dq_ff <= {dq_ff[DIV_BITS-2:0], 1'b0};
               end
            end
         end
      endcase
      case (cmd.div_save)
         DIV_RMEAN: rmean_ff <= dq_ff[SAMPLE_BITS-1:0];
         DIV_IMEAN: imean_ff <= dq_ff[SAMPLE_BITS-1:0];
         DIV_RATIO: ratio_ff <= sat ? R_MAX_Q16 : dq_ff[RATIO_BITS-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.root_load)
         ROOT_RED: begin
            rv_ff <= rsqsum_ff;
            rr_ff <= '0;
            rb_ff <= SQ_BITS'(1) << (SQ_BITS - 2);
         end
         ROOT_IR: begin
            rv_ff <= isqsum_ff;
            rr_ff <= '0;
            rb_ff <= SQ_BITS'(1) << (SQ_BITS - 2);
         end
         default: begin
            if (cmd.root_step) begin
               if (rv_ff >= rtry) begin
                  rv_ff <= rv_ff - rtry;
                  rr_ff <= (rr_ff >> 1) + rb_ff;
               end else begin
                  rr_ff <= rr_ff >> 1;
               end
               rb_ff <= rb_ff >> 2;
            end
         end
      endcase
      case (cmd.root_save)
         ROOT_RED: root_r_ff <= rr_ff[ROOT_STEPS-1:0];
         ROOT_IR: root_i_ff <= rr_ff[ROOT_STEPS-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_ratio) begin
         num_ff <= NUMW'(root_r_ff) * NUMW'(imean_ff);
         den_ff <= NUMW'(root_i_ff) * NUMW'(rmean_ff);
      end
      if (cmd.scale) begin
         prod_ff <= PROD_BITS'(CONST_SLOPE_Q16) * PROD_BITS'(ratio_ff);
      end
      if (cmd.finish) begin
         err_ff <= status.zero_err;
         if (status.zero_err || prod_ff >= off) begin
            pct_ff <= '0;
         end else begin
            pct_ff <= diff[32 +: PCT_BITS];
         end
      end
   end

endmodule
